>>> hdl/lz78_pkg.sv
`timescale 1ns / 1ps

package lz78_pkg;

    localparam int NODE_W  = 12;
    localparam int SYM_W   = 8;
    localparam int KEY_W   = NODE_W + SYM_W;
    localparam int CFG_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int S_DW    = 8;
    localparam int M_DW    = 40;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [SYM_W-1:0]  sym_t;

    localparam node_t LIMIT_RST = node_t'(4095);

    // register index, taken from paddr[2]
    localparam logic REG_NODE_LIMIT = 1'b0;

    // one child map slot
    typedef struct packed {
        logic  valid;
        node_t parent;
        sym_t  sym;
        node_t child;
    } entry_t;

    // result transaction, phrase_emitted in the lowest bit
    typedef struct packed {
        node_t node_count;
        node_t current_node;
        logic  dict_full;
        node_t phrase_index;
        logic  phrase_emitted;
    } res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

endpackage

>>> hdl/lz78_dictionary_encoder_core.sv
// LZ78 trie encoder: one byte per input transaction, one result per byte.
// The child map is a linear-probe hash table of 2**$clog2(DICT_SIZE) slots in a
// single-port-read, single-port-write synchronous RAM, keyed by (current node,
// byte). The probe starts at the key's home slot and reads each occupied slot of
// another key in turn until it hits or finds an empty slot. On a miss, unless the
// dictionary is full, the new node is written to the empty slot found, in the same
// cycle the result is registered. The result register lets the next byte be taken
// while a result waits; a byte resolving into a full result register waits there.
// After reset the table is cleared one slot per cycle with s_tready low; APB
// writes are taken during that pass. Pairing bytes with phrase numbers is the
// caller's job.
`timescale 1ns / 1ps

module lz78_dictionary_encoder_core #(
    parameter int DICT_SIZE = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lz78_pkg::S_DW-1:0]     s_tdata,   // [7:0] symbol
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lz78_pkg::M_DW-1:0]     m_tdata,   // [0] phrase_emitted, [12:1] phrase_index,
                                                     // [13] dict_full, [25:14] current_node,
                                                     // [37:26] node_count, [39:38] zero
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lz78_pkg::CFG_AW-1:0]   paddr,
    input  logic [lz78_pkg::APB_DW-1:0]   pwdata,
    output logic [lz78_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lz78_pkg::*;

    localparam int AW     = $clog2(DICT_SIZE);
    localparam int CHUNKS = (KEY_W + AW - 1) / AW;

    state_t          state_reg;
    state_t          state_next;
    node_t           pos_reg;
    node_t           pos_next;
    node_t           added_reg;
    node_t           added_next;
    sym_t            sym_reg;
    sym_t            sym_next;
    logic [AW-1:0]   probe_addr_reg;
    logic [AW-1:0]   probe_addr_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   clr_addr_next;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    res_t            res_reg;
    res_t            res_next;

    node_t           node_limit;
    logic [KEY_W-1:0] key;
    logic [AW-1:0]   home_addr;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    entry_t          rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_data;

    logic            hit;
    logic            empty;
    logic            out_free;
    logic            full;
    logic            resolve;
    logic            insert;

    lz78_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .node_limit (node_limit)
    );

    lz78_ram #(
        .AW (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // xor-fold of {node, byte} into a slot number
    assign key = {pos_reg, s_tdata[SYM_W-1:0]};

    always_comb
    begin
        home_addr = '0;
        for (int k = 0; k < CHUNKS; k++)
        begin
            home_addr = home_addr ^ AW'(key >> (k * AW));
        end
    end

    assign hit      = rd_data.valid && (rd_data.parent == pos_reg) && (rd_data.sym == sym_reg);
    assign empty    = !rd_data.valid;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (added_reg >= node_limit) ||
                      ((32'(added_reg) + 32'd1) >= 32'(DICT_SIZE));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if ((hit || empty) && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = home_addr;
        wr_en    = 1'b0;
        wr_addr  = probe_addr_reg;
        wr_data  = '0;
        resolve  = 1'b0;
        insert   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                rd_en    = s_tvalid;
                rd_addr  = home_addr;
            end
            ST_PROBE:
            begin
                if (!hit && !empty)
                begin
                    rd_en   = 1'b1;
                    rd_addr = probe_addr_reg + AW'(1);
                end
                else if (out_free)
                begin
                    resolve = 1'b1;
                    insert  = empty && !full;
                    wr_en   = empty && !full;
                    wr_data = '{valid: 1'b1, parent: pos_reg, sym: sym_reg,
                                child: added_reg + node_t'(1)};
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next        = pos_reg;
        added_next      = added_reg;
        sym_next        = sym_reg;
        probe_addr_next = probe_addr_reg;
        clr_addr_next   = clr_addr_reg;
        res_next        = res_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        if (state_reg == ST_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (rd_en)
        begin
            probe_addr_next = rd_addr;
        end

        if (s_tvalid && s_tready)
        begin
            sym_next = s_tdata[SYM_W-1:0];
        end

        if (resolve)
        begin
            m_tvalid_next = 1'b1;
            if (hit)
            begin
                pos_next = rd_data.child;
                res_next = '{node_count: added_reg, current_node: rd_data.child,
                             dict_full: 1'b0, phrase_index: '0, phrase_emitted: 1'b0};
            end
            else if (insert)
            begin
                pos_next   = '0;
                added_next = added_reg + node_t'(1);
                res_next   = '{node_count: added_reg + node_t'(1), current_node: '0,
                               dict_full: 1'b0, phrase_index: pos_reg, phrase_emitted: 1'b1};
            end
            else
            begin
                pos_next = '0;
                res_next = '{node_count: added_reg, current_node: '0,
                             dict_full: 1'b1, phrase_index: '0, phrase_emitted: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pos_reg      <= '0;
            added_reg    <= '0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            added_reg    <= added_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        probe_addr_reg <= probe_addr_next;
        res_reg        <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DW'(res_reg);

    a_insert_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == ST_PROBE) |-> !rd_data.valid)
        else $error("insert over an occupied slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        resolve |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(added_reg) |-> (added_reg == $past(added_reg) + node_t'(1)))
        else $error("node count jumped");

    a_miss_root: assert property (@(posedge clk) disable iff (!rst_n)
        (resolve && !hit) |=> (pos_reg == '0))
        else $error("trie pointer not at root after miss");

endmodule

>>> hdl/lz78_ram.sv
`timescale 1ns / 1ps

module lz78_ram #(
    parameter int AW = 12
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  lz78_pkg::entry_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output lz78_pkg::entry_t rd_data
);
    import lz78_pkg::*;

    entry_t mem [2**AW];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/lz78_apb.sv
`timescale 1ns / 1ps

module lz78_apb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lz78_pkg::CFG_AW-1:0]   paddr,
    input  logic [lz78_pkg::APB_DW-1:0]   pwdata,
    output logic [lz78_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output lz78_pkg::node_t               node_limit
);
    import lz78_pkg::*;

    node_t node_limit_reg;
    node_t node_limit_next;
    logic  reg_idx;
    logic  wr_stb;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_stb  = psel & penable & pwrite & pready;

    always_comb
    begin
        node_limit_next = node_limit_reg;
        prdata          = '0;
        unique case (reg_idx)
            REG_NODE_LIMIT:
            begin
                prdata = APB_DW'(node_limit_reg);
                if (wr_stb)
                begin
                    node_limit_next = pwdata[NODE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_limit_reg <= LIMIT_RST;
        end
        else
        begin
            node_limit_reg <= node_limit_next;
        end
    end

    assign node_limit = node_limit_reg;

endmodule
